/* rtl/aeg_pkg.sv */
package aeg_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned LEVEL_W = 18;
  localparam int unsigned PHASE_W = 3;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_TRIG = 1'b1;

  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_ACTIVE,
    RUN_DONE
  } run_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_FINISH  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_PUSH
  } core_st_e;

endpackage

/* rtl/aeg_stream_if.sv */
interface aeg_in_if import aeg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [FIELD_W-1:0]        attack_ms;
  logic [FIELD_W-1:0]        sustain_ms;
  logic [FIELD_W-1:0]        release_ms;
  logic [FIELD_W-1:0]        gain;
  logic signed [FIELD_W-1:0] offset;

  modport source (
    output valid, mode, attack_ms, sustain_ms, release_ms, gain, offset,
    input  ready
  );
  modport sink (
    input  valid, mode, attack_ms, sustain_ms, release_ms, gain, offset,
    output ready
  );
endinterface

interface aeg_out_if import aeg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level;
  logic                      level_valid;
  logic [PHASE_W-1:0]        phase;

  modport source (
    output valid, level, level_valid, phase,
    input  ready
  );
  modport sink (
    input  valid, level, level_valid, phase,
    output ready
  );
endinterface

/* rtl/aeg_div.sv */
module aeg_div import aeg_pkg::*; #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [TIME_BITS+4:0]     num_i,
  input  logic [TIME_BITS+4:0]     den_i,
  output logic                     busy_o,
  output logic [FRAC_BITS-1:0]     quo_o
);

  localparam int unsigned DW = TIME_BITS + 5;
  localparam int unsigned CW = $clog2(FRAC_BITS);

  logic              busy_q, busy_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     rem_q;
  logic [DW-1:0]     den_q;
  logic [FRAC_BITS-1:0] quo_q;

  logic [DW:0]       two_rem;
  logic [DW:0]       diff;
  logic              ge;
  logic [DW-1:0]     rem_step;

  // The numerator is always below the divisor, so each step yields one
  // quotient bit and the partial remainder stays below the divisor.
  assign two_rem  = {rem_q, 1'b0};
  assign ge       = (two_rem >= {1'b0, den_q});
  assign diff     = two_rem - {1'b0, den_q};
  assign rem_step = ge ? diff[DW-1:0] : two_rem[DW-1:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(FRAC_BITS - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_step;
      quo_q <= {quo_q[FRAC_BITS-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/asr_envelope_generator_top.sv */
// Linear attack-sustain-release envelope generator timed in milliseconds. A request with
// mode 1 loads the attack, sustain and release lengths, gain and bias and restarts time at
// zero; it produces no result and the block is ready again on the next cycle. A request
// with mode 0 is one millisecond tick and produces exactly one result. Ticks while idle or
// done, and the finishing tick that returns the bias alone, skip the arithmetic. A sustain
// tick passes through the bit-serial shift-add multiplier that scales the gain. Attack and
// release ticks pass first through the restoring divider that produces one envelope bit
// per cycle and then through the multiplier. A finished result sits in an output register,
// so the next request is taken while it waits for the consumer.
module asr_envelope_generator_top import aeg_pkg::*; #(
  parameter int unsigned TIME_BITS = 16,
  parameter int unsigned FRAC_BITS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aeg_in_if.sink    in_i,
  aeg_out_if.source out_o
);

  localparam int unsigned EW  = TIME_BITS + 2;
  localparam int unsigned AW  = TIME_BITS + 1;
  localparam int unsigned DW  = TIME_BITS + 5;
  localparam int unsigned PW  = FIELD_W + FRAC_BITS + 1;
  localparam int unsigned MCW = $clog2(FRAC_BITS + 1);

  localparam logic [EW-1:0]        ELAPSED_MAX = '1;
  localparam logic [FRAC_BITS:0]   ENV_ONE     = {1'b1, {FRAC_BITS{1'b0}}};

  // Control and envelope state.
  core_st_e                  st_q, st_d;
  run_e                      run_q;
  logic [EW-1:0]             elapsed_q;
  logic [TIME_BITS-1:0]      att_q;
  logic [TIME_BITS-1:0]      rel_q;
  logic [AW-1:0]             as_sum_q;
  logic [EW-1:0]             total_q;
  logic [FIELD_W-1:0]        gain_q;
  logic signed [FIELD_W-1:0] offset_q;
  logic [MCW-1:0]            mcnt_q;
  logic                      out_valid_q, out_valid_d;

  // Datapath registers.
  logic                      is_rel_q;
  logic [PW-1:0]             prod_q;
  logic signed [LEVEL_W-1:0] res_level_q;
  logic                      res_lv_q;
  phase_e                    res_phase_q;
  logic signed [LEVEL_W-1:0] out_level_q;
  logic                      out_lv_q;
  phase_e                    out_phase_q;

  logic                      in_accept;
  logic                      is_trig;
  logic                      active;
  logic                      at_end;
  logic                      in_att;
  logic                      in_sus;
  logic                      need_div;
  logic                      tick_go;
  logic                      out_free;
  logic                      push;
  phase_e                    tick_phase;
  logic [TIME_BITS-1:0]      rel_t;
  logic [DW-1:0]             div_num;
  logic [DW-1:0]             div_den;
  logic                      div_busy;
  logic [FRAC_BITS-1:0]      div_quo;
  logic [FRAC_BITS:0]        env_div;
  logic [FIELD_W:0]          mul_sum;
  logic [PW-1:0]             prod_step;
  logic signed [LEVEL_W-1:0] mul_level;
  logic signed [LEVEL_W-1:0] bias_level;
  logic [AW-1:0]             trig_as_sum;

  assign in_accept = in_i.valid && in_i.ready;
  assign is_trig   = (in_i.mode == MODE_TRIG);
  assign active    = (run_q == RUN_ACTIVE);
  assign at_end    = (elapsed_q >= total_q);
  assign in_att    = (elapsed_q < EW'(att_q));
  assign in_sus    = (elapsed_q < EW'(as_sum_q));
  assign tick_go   = (st_q == ST_IDLE) && in_accept && !is_trig;
  assign need_div  = active && !at_end && (in_att || !in_sus);
  assign out_free  = !out_valid_q || out_o.ready;
  assign push      = (st_q == ST_PUSH) && out_free;

  always_comb begin
    priority if (!active) begin
      tick_phase = PH_IDLE;
    end else if (at_end) begin
      tick_phase = PH_FINISH;
    end else if (in_att) begin
      tick_phase = PH_ATTACK;
    end else if (in_sus) begin
      tick_phase = PH_SUSTAIN;
    end else begin
      tick_phase = PH_RELEASE;
    end
  end

  // Release divides 20*t by 21*r, which is t over 1.05 times the release length.
  assign rel_t   = TIME_BITS'(elapsed_q - EW'(as_sum_q));
  assign div_num = in_att ? DW'(elapsed_q)
                          : (DW'(rel_t) << 4) + (DW'(rel_t) << 2);
  assign div_den = in_att ? DW'(att_q)
                          : (DW'(rel_q) << 4) + (DW'(rel_q) << 2) + DW'(rel_q);

  aeg_div #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tick_go && need_div),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign env_div = is_rel_q ? (ENV_ONE - {1'b0, div_quo}) : {1'b0, div_quo};

  // Shift-add multiply: the envelope sits in the low bits and is consumed one
  // bit per cycle while the gain is added into the upper half.
  assign mul_sum   = {1'b0, prod_q[PW-1:FRAC_BITS+1]}
                   + {1'b0, (prod_q[0] ? gain_q : FIELD_W'(0))};
  assign prod_step = {mul_sum, prod_q[FRAC_BITS:1]};

  assign bias_level = {{(LEVEL_W-FIELD_W){offset_q[FIELD_W-1]}}, offset_q};
  assign mul_level  = bias_level
                    + $signed({2'b00, prod_step[FRAC_BITS+FIELD_W-1:FRAC_BITS]});

  assign trig_as_sum = AW'(TIME_BITS'(in_i.attack_ms)) + AW'(TIME_BITS'(in_i.sustain_ms));

  // Next-state logic.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_accept && !is_trig) begin
          if (!active || at_end) begin
            st_d = ST_PUSH;
          end else if (need_div) begin
            st_d = ST_DIV;
          end else begin
            st_d = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mcnt_q == '0) begin
          st_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Input ready and output-side control.
  always_comb begin
    in_i.ready  = (st_q == ST_IDLE);
    out_valid_d = push || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      run_q       <= RUN_IDLE;
      elapsed_q   <= '0;
      att_q       <= '0;
      rel_q       <= '0;
      as_sum_q    <= '0;
      total_q     <= '0;
      gain_q      <= '0;
      offset_q    <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if ((st_q == ST_IDLE) && in_accept) begin
        if (is_trig) begin
          att_q     <= TIME_BITS'(in_i.attack_ms);
          rel_q     <= TIME_BITS'(in_i.release_ms);
          as_sum_q  <= trig_as_sum;
          total_q   <= EW'(trig_as_sum) + EW'(TIME_BITS'(in_i.release_ms));
          gain_q    <= in_i.gain;
          offset_q  <= in_i.offset;
          elapsed_q <= '0;
          run_q     <= RUN_ACTIVE;
        end else if (active) begin
          if (at_end) begin
            run_q <= RUN_DONE;
          end else if (elapsed_q != ELAPSED_MAX) begin
            elapsed_q <= elapsed_q + 1'b1;
          end
        end
      end
      if (tick_go || ((st_q == ST_DIV) && !div_busy)) begin
        mcnt_q <= MCW'(FRAC_BITS);
      end else if (st_q == ST_MUL) begin
        mcnt_q <= mcnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      res_phase_q <= tick_phase;
      res_lv_q    <= active;
      res_level_q <= (active && at_end) ? bias_level : '0;
      is_rel_q    <= !in_att;
      prod_q      <= {FIELD_W'(0), ENV_ONE};
    end else if ((st_q == ST_DIV) && !div_busy) begin
      prod_q <= {FIELD_W'(0), env_div};
    end else if (st_q == ST_MUL) begin
      prod_q <= prod_step;
      if (mcnt_q == '0) begin
        res_level_q <= mul_level;
      end
    end
    if (push) begin
      out_level_q <= res_level_q;
      out_lv_q    <= res_lv_q;
      out_phase_q <= res_phase_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.level       = out_level_q;
  assign out_o.level_valid = out_lv_q;
  assign out_o.phase       = out_phase_q;

endmodule

/* rtl/aeg_chk.sv */
module aeg_chk import aeg_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_mode_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [LEVEL_W-1:0] out_level_i,
  input logic                      out_level_valid_i,
  input logic [PHASE_W-1:0]        out_phase_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_level_i)
      && $stable(out_level_valid_i) && $stable(out_phase_i))
    else $error("result changed while stalled");

  a_phase_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_level_valid_i == (out_phase_i != PH_IDLE)))
    else $error("level_valid disagrees with phase");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_level_valid_i |-> (out_level_i == '0))
    else $error("idle result carries a nonzero level");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_mode_i == MODE_TICK) |=> !in_ready_i)
    else $error("tick request did not occupy the core");

  a_trig_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_mode_i == MODE_TRIG) |=> !$rose(out_valid_i))
    else $error("trigger request produced a result");

endmodule

bind asr_envelope_generator_top aeg_chk u_aeg_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_mode_i         (in_i.mode),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_level_i       (out_o.level),
  .out_level_valid_i (out_o.level_valid),
  .out_phase_i       (out_o.phase)
);

/* dv/tb_asr_envelope_generator_top.sv */
`timescale 1ns / 1ps

module tb_asr_envelope_generator_top;
  import aeg_pkg::*;

  localparam int unsigned TIME_BITS   = 16;
  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned N_ITEMS     = 650;
  localparam int unsigned MAX_WAIT    = 18;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam longint unsigned ENV_ONE = 64'd1 << FRAC_BITS;
  // The release divisor is 1.05 times the release length, kept exact as 21/20.
  localparam longint unsigned REL_NUM = 20;
  localparam longint unsigned REL_DEN = 21;

  typedef struct {
    logic                      mode;
    logic [FIELD_W-1:0]        attack_ms;
    logic [FIELD_W-1:0]        sustain_ms;
    logic [FIELD_W-1:0]        release_ms;
    logic [FIELD_W-1:0]        gain;
    logic signed [FIELD_W-1:0] offset;
    int unsigned               gap;
    bit                        drain;
    bit                        hold;
  } env_req_t;

  typedef struct {
    logic signed [LEVEL_W-1:0] level;
    logic                      level_valid;
    logic [PHASE_W-1:0]        phase;
  } level_res_t;

  logic clk_i;
  logic rst_ni;

  aeg_in_if  in_if ();
  aeg_out_if out_if ();

  asr_envelope_generator_top #(
    .TIME_BITS(TIME_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Envelope state as the block should hold it.
  run_e                      run_q       = RUN_IDLE;
  logic [TIME_BITS+1:0]      elapsed_q   = '0;
  logic [TIME_BITS-1:0]      attack_q    = '0;
  logic [TIME_BITS-1:0]      sustain_q   = '0;
  logic [TIME_BITS-1:0]      release_q   = '0;
  logic [FIELD_W-1:0]        gain_q      = '0;
  logic signed [FIELD_W-1:0] offset_q    = '0;

  env_req_t   pend_q[$];
  level_res_t level_q[$];
  env_req_t   cur_req;
  bit         have_cur  = 1'b0;
  bit         offering  = 1'b0;
  int unsigned gap_left = 0;
  bit         took_req  = 1'b0;
  bit         took_rsp  = 1'b0;
  bit         hold_go   = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_wait  = 0;
  int unsigned rx_burst = 0;
  int unsigned tx_burst = 0;
  int unsigned n_queued = 0;
  int unsigned n_trig   = 0;
  int unsigned n_tick   = 0;
  int unsigned n_checked = 0;
  int unsigned err_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned ph_cnt[5] = '{default: 0};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit predict_level(input env_req_t req, output level_res_t res);
    longint unsigned e, tot, env, t, ratio;
    longint signed lvl;
    phase_e ph;
    res.level       = '0;
    res.level_valid = 1'b0;
    res.phase       = PH_IDLE;
    if (req.mode == MODE_TRIG) begin
      attack_q  = req.attack_ms;
      sustain_q = req.sustain_ms;
      release_q = req.release_ms;
      gain_q    = req.gain;
      offset_q  = req.offset;
      elapsed_q = '0;
      run_q     = RUN_ACTIVE;
      return 1'b0;
    end
    if (run_q != RUN_ACTIVE) return 1'b1;
    e   = elapsed_q;
    tot = longint'(attack_q) + longint'(sustain_q) + longint'(release_q);
    if (e >= tot) begin
      run_q           = RUN_DONE;
      lvl             = longint'(offset_q);
      res.level       = lvl[LEVEL_W-1:0];
      res.level_valid = 1'b1;
      res.phase       = PH_FINISH;
      return 1'b1;
    end
    if (e < attack_q) begin
      env = (e << FRAC_BITS) / longint'(attack_q);
      ph  = PH_ATTACK;
    end else if (e < longint'(attack_q) + longint'(sustain_q)) begin
      env = ENV_ONE;
      ph  = PH_SUSTAIN;
    end else begin
      // Here the release length is nonzero, since e lies below the total.
      t     = e - attack_q - sustain_q;
      ratio = ((REL_NUM * t) << FRAC_BITS) / (REL_DEN * longint'(release_q));
      if (ratio > ENV_ONE) ratio = ENV_ONE;
      env = ENV_ONE - ratio;
      ph  = PH_RELEASE;
    end
    lvl             = longint'(offset_q) + longint'((env * longint'(gain_q)) >> FRAC_BITS);
    res.level       = lvl[LEVEL_W-1:0];
    res.level_valid = 1'b1;
    res.phase       = ph;
    if (elapsed_q != '1) elapsed_q = elapsed_q + 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] rnd16();
    return FIELD_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Sender gaps are random, with occasional random stretches with no gap at all.
  function automatic int unsigned draw_gap();
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      tx_burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void add_req(input logic mode, input logic [FIELD_W-1:0] att, sus, rel,
                                  input logic [FIELD_W-1:0] gn, ofs,
                                  input bit drain = 1'b0, input bit hold = 1'b0);
    env_req_t r;
    r.mode       = mode;
    r.attack_ms  = att;
    r.sustain_ms = sus;
    r.release_ms = rel;
    r.gain       = gn;
    r.offset     = ofs;
    r.gap        = draw_gap();
    r.drain      = drain;
    r.hold       = hold;
    pend_q.push_back(r);
    n_queued++;
  endfunction

  function automatic void add_tick(input bit drain = 1'b0);
    add_req(MODE_TICK, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), drain);
  endfunction

  // Request driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (offering && took_req) begin
        offering = 1'b0;
        have_cur = 1'b0;
      end
      if (!have_cur && pend_q.size() != 0) begin
        cur_req  = pend_q.pop_front();
        have_cur = 1'b1;
        gap_left = cur_req.gap;
      end
      if (have_cur && !offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!cur_req.drain || level_q.size() == 0) begin
          in_if.mode       <= cur_req.mode;
          in_if.attack_ms  <= cur_req.attack_ms;
          in_if.sustain_ms <= cur_req.sustain_ms;
          in_if.release_ms <= cur_req.release_ms;
          in_if.gain       <= cur_req.gain;
          in_if.offset     <= cur_req.offset;
          offering = 1'b1;
        end
      end
      in_if.valid <= offering;
    end
  end

  // Result receiver: a random wait per result, plus one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (took_rsp) begin
        if (rx_burst > 0) begin
          rx_burst--;
          rx_wait = 0;
        end else if ($urandom_range(0, 24) == 0) begin
          rx_burst = $urandom_range(8, 40);
          rx_wait  = 0;
        end else begin
          rx_wait = $urandom_range(0, MAX_WAIT);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Acceptance, prediction and result checking.
  always @(posedge clk_i) begin
    level_res_t exp_res;
    level_res_t new_res;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("tb_asr_envelope_generator_top: done, errors");
        $finish;
      end else begin
        took_req = in_if.valid && in_if.ready;
        took_rsp = out_if.valid && out_if.ready;
        if (took_rsp) begin
          if (level_q.size() == 0) begin
            $error("result with no request pending: level %0d phase %0d",
                   out_if.level, out_if.phase);
            err_cnt++;
          end else begin
            exp_res = level_q.pop_front();
            n_checked++;
            if (out_if.level !== exp_res.level) begin
              $error("level: expected %0d, got %0d", exp_res.level, out_if.level);
              err_cnt++;
            end
            if (out_if.level_valid !== exp_res.level_valid) begin
              $error("level_valid: expected %0d, got %0d",
                     exp_res.level_valid, out_if.level_valid);
              err_cnt++;
            end
            if (out_if.phase !== exp_res.phase) begin
              $error("phase: expected %0d, got %0d", exp_res.phase, out_if.phase);
              err_cnt++;
            end
          end
        end
        if (took_req) begin
          if (cur_req.hold) hold_go = 1'b1;
          if (cur_req.mode == MODE_TRIG) n_trig++;
          else n_tick++;
          if (predict_level(cur_req, new_res)) begin
            level_q.push_back(new_res);
            ph_cnt[new_res.phase]++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned pick, lim, n_ticks, tot;
    logic [FIELD_W-1:0] a, s, r;
    bit hold_done;
    hold_done        = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_TICK;
    in_if.attack_ms  = '0;
    in_if.sustain_ms = '0;
    in_if.release_ms = '0;
    in_if.gain       = '0;
    in_if.offset     = '0;
    out_if.ready     = 1'b0;

    // Tick before any trigger, then an all-zero envelope that finishes at once.
    add_tick();
    add_req(MODE_TRIG, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    repeat (2) add_tick();
    // Short full envelope at the largest level.
    add_req(MODE_TRIG, 16'd2, 16'd1, 16'd2, 16'hFFFF, 16'h7FFF);
    repeat (6) add_tick();
    // Longest lengths and the most negative bias, then a restart mid-envelope.
    add_req(MODE_TRIG, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h8000);
    repeat (2) add_tick();
    add_req(MODE_TRIG, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h8000);
    repeat (2) add_tick();
    add_req(MODE_TRIG, 16'd1, 16'd0, 16'd0, 16'h5555, 16'h5555);
    add_tick();
    add_tick();
    add_tick(1'b1);

    while (n_queued < N_ITEMS) begin
      if (!hold_done && n_queued >= N_ITEMS / 2) begin
        // The receiver holds off once this trigger is taken; ticks keep coming back to back.
        hold_done = 1'b1;
        add_req(MODE_TRIG, 16'd3, 16'd4, 16'd5, rnd16(), rnd16(), 1'b0, 1'b1);
        tx_burst = 40;
        repeat (24) add_tick();
        tx_burst = 0;
        add_tick(1'b1);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        add_req(MODE_TRIG, rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
        repeat ($urandom_range(0, 3)) add_tick();
      end else if (pick == 1) begin
        add_tick();
      end else begin
        lim = ($urandom_range(0, 4) == 0) ? 24 : 6;
        a = FIELD_W'($urandom_range(0, lim));
        s = FIELD_W'($urandom_range(0, lim));
        r = FIELD_W'($urandom_range(0, lim));
        add_req(MODE_TRIG, a, s, r, rnd16(), rnd16());
        tot = a + s + r;
        if ($urandom_range(0, 5) == 0) n_ticks = $urandom_range(0, tot);
        else n_ticks = tot + 1 + $urandom_range(0, 2);
        repeat (n_ticks) add_tick();
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_q.size() != 0 || have_cur) @(posedge clk_i);
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests taken (%0d triggers, %0d ticks), %0d results checked",
             n_trig + n_tick, n_trig, n_tick, n_checked);
    $display("results by phase: idle %0d, attack %0d, sustain %0d, release %0d, finish %0d",
             ph_cnt[PH_IDLE], ph_cnt[PH_ATTACK], ph_cnt[PH_SUSTAIN], ph_cnt[PH_RELEASE],
             ph_cnt[PH_FINISH]);
    if (err_cnt == 0) begin
      $display("tb_asr_envelope_generator_top: done, clean");
    end else begin
      $display("tb_asr_envelope_generator_top: done, errors");
    end
    $finish;
  end

endmodule
